[rtl/sem_pkg.sv]
`timescale 1ns / 1ps
// Shared types, constants and the Scharr magnitude function for the
// 3x3 edge-magnitude block. No dependencies.
package sem_pkg;

    localparam int MAX_WIDTH      = 2048;
    localparam int PIXEL_BITS     = 8;
    localparam int COL_BITS       = $clog2(MAX_WIDTH);
    localparam int EFF_WIDTH_BITS = COL_BITS + 1;
    localparam int WIDTH_BITS     = 12;
    localparam int HEIGHT_BITS    = 16;
    localparam int CFG_DATA_BITS  = 16;
    localparam int CFG_INDEX_BITS = 1;

    localparam logic [WIDTH_BITS-1:0]  WIDTH_RESET  = 12'd640;
    localparam logic [HEIGHT_BITS-1:0] HEIGHT_RESET = 16'd480;

    typedef enum logic [CFG_INDEX_BITS-1:0] {
        REG_IMAGE_WIDTH  = 1'b0,
        REG_IMAGE_HEIGHT = 1'b1
    } cfg_reg_t;

    typedef enum logic {
        MODE_PIXEL = 1'b0,
        MODE_FLUSH = 1'b1
    } item_mode_t;

    typedef logic [PIXEL_BITS-1:0] pixel_t;

    // Nine window pixels, index col*3 + row: col 0 is left, row 0 is top.
    typedef logic [8:0][PIXEL_BITS-1:0] window_t;

    // Decisions taken when a beat is accepted, carried down the pipeline.
    typedef struct packed {
        logic [COL_BITS-1:0] col;
        logic                top_from_mid;
        logic                take_pixel;
        logic                first_col;
        logic                started;
        logic                row_end;
        logic                image_end;
    } item_info_t;

    typedef struct packed {
        logic    valid;
        window_t win;
        logic    row_end;
        logic    image_end;
    } grad_beat_t;

    // 3*(a+c) + 10*b with shifts and adds; at most 4080.
    function automatic logic signed [13:0] scharr_tap(input pixel_t a, input pixel_t b,
                                                      input pixel_t c);
        logic signed [13:0] ac;
        logic signed [13:0] bb;
        ac = 14'(a) + 14'(c);
        bb = 14'(b);
        return (ac <<< 1) + ac + (bb <<< 3) + (bb <<< 1);
    endfunction

    function automatic pixel_t scharr_mag(input window_t p);
        logic signed [13:0] gx;
        logic signed [13:0] gy;
        logic [12:0]        ax;
        logic [12:0]        ay;
        logic [13:0]        sum;
        logic [11:0]        quarter;
        gx = scharr_tap(p[0], p[1], p[2]) - scharr_tap(p[6], p[7], p[8]);
        gy = scharr_tap(p[0], p[3], p[6]) - scharr_tap(p[2], p[5], p[8]);
        ax = gx[13] ? 13'(-gx) : gx[12:0];
        ay = gy[13] ? 13'(-gy) : gy[12:0];
        sum = 14'(ax) + 14'(ay);
        quarter = sum[13:2];
        return (quarter > 12'd255) ? 8'hFF : quarter[7:0];
    endfunction

endpackage

[rtl/sem_line_ram.sv]
`timescale 1ns / 1ps
// Generic simple dual-port RAM: one write port, one read port with a
// registered read. No dependencies.
module sem_line_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2048
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem_reg[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/sem_ctrl.sv]
`timescale 1ns / 1ps
// Configuration registers and the input/output position counters.
// Decides per accepted beat where it lands and whether it yields a result. Uses sem_pkg.
module sem_ctrl (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                cfg_wr_en,
    input  logic [sem_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
    input  logic [sem_pkg::CFG_DATA_BITS-1:0]   cfg_data,
    input  logic                                accept,
    input  sem_pkg::item_mode_t                 mode,
    output sem_pkg::item_info_t                 info
);
    import sem_pkg::*;

    logic [WIDTH_BITS-1:0]  width_reg,  width_next;
    logic [HEIGHT_BITS-1:0] height_reg, height_next;
    logic [COL_BITS-1:0]    col_reg,    col_next;
    logic [HEIGHT_BITS-1:0] row_reg,    row_next;
    logic [COL_BITS-1:0]    ocol_reg,   ocol_next;
    logic [HEIGHT_BITS-1:0] orow_reg,   orow_next;

    logic [EFF_WIDTH_BITS-1:0] eff_w;
    logic [HEIGHT_BITS-1:0]    eff_h;
    logic [COL_BITS-1:0]       x;
    logic [EFF_WIDTH_BITS-1:0] x_inc;
    logic [EFF_WIDTH_BITS-1:0] ocol_inc;
    logic [HEIGHT_BITS:0]      orow_inc;
    logic                      started;
    logic                      row_end;
    logic                      image_end;

    always_comb begin
        if (width_reg == '0) begin
            eff_w = EFF_WIDTH_BITS'(1);
        end else if (32'(width_reg) > 32'(MAX_WIDTH)) begin
            eff_w = EFF_WIDTH_BITS'(MAX_WIDTH);
        end else begin
            eff_w = EFF_WIDTH_BITS'(width_reg);
        end
        eff_h = (height_reg == '0) ? HEIGHT_BITS'(1) : height_reg;

        // A column left over from a wider setting restarts the row.
        x = (EFF_WIDTH_BITS'(col_reg) >= eff_w) ? '0 : col_reg;
        x_inc = EFF_WIDTH_BITS'(x) + EFF_WIDTH_BITS'(1);

        started   = (row_reg >= HEIGHT_BITS'(2)) ||
                    ((row_reg == HEIGHT_BITS'(1)) && (x != '0));
        ocol_inc  = EFF_WIDTH_BITS'(ocol_reg) + EFF_WIDTH_BITS'(1);
        orow_inc  = (HEIGHT_BITS+1)'(orow_reg) + (HEIGHT_BITS+1)'(1);
        row_end   = started && (ocol_inc >= eff_w);
        image_end = row_end && (orow_inc >= (HEIGHT_BITS+1)'(eff_h));

        info.col          = x;
        info.top_from_mid = (row_reg <= HEIGHT_BITS'(1));
        info.take_pixel   = (mode == MODE_PIXEL) && (row_reg < eff_h);
        info.first_col    = (x == '0);
        info.started      = started;
        info.row_end      = row_end;
        info.image_end    = image_end;
    end

    always_comb begin
        width_next  = width_reg;
        height_next = height_reg;
        if (cfg_wr_en) begin
            unique case (cfg_reg_t'(cfg_index))
                REG_IMAGE_WIDTH:  width_next  = cfg_data[WIDTH_BITS-1:0];
                REG_IMAGE_HEIGHT: height_next = cfg_data[HEIGHT_BITS-1:0];
            endcase
        end
    end

    always_comb begin
        col_next  = col_reg;
        row_next  = row_reg;
        ocol_next = ocol_reg;
        orow_next = orow_reg;
        if (accept) begin
            if (started) begin
                ocol_next = row_end ? '0 : ocol_inc[COL_BITS-1:0];
                if (row_end && !image_end) begin
                    orow_next = orow_inc[HEIGHT_BITS-1:0];
                end
            end
            if (image_end) begin
                col_next  = '0;
                row_next  = '0;
                ocol_next = '0;
                orow_next = '0;
            end else if (x_inc >= eff_w) begin
                col_next = '0;
                row_next = row_reg + HEIGHT_BITS'(1);
            end else begin
                col_next = x_inc[COL_BITS-1:0];
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_RESET;
            height_reg <= HEIGHT_RESET;
            col_reg    <= '0;
            row_reg    <= '0;
            ocol_reg   <= '0;
            orow_reg   <= '0;
        end else begin
            width_reg  <= width_next;
            height_reg <= height_next;
            col_reg    <= col_next;
            row_reg    <= row_next;
            ocol_reg   <= ocol_next;
            orow_reg   <= orow_next;
        end
    end

    // The last pixel of an image returns every position counter to zero.
    a_image_end_clears: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && info.image_end |=>
            (col_reg == '0) && (row_reg == '0) && (ocol_reg == '0) && (orow_reg == '0))
        else $error("counters not cleared after image end");

    // Beats that yield no result leave the output position alone.
    a_no_result_holds_out: assert property (@(posedge aclk) disable iff (!aresetn)
        accept && !info.started |=> $stable(ocol_reg) && $stable(orow_reg))
        else $error("output position moved without a result");

endmodule

[rtl/sem_window.sv]
`timescale 1ns / 1ps
// Two line stores and the 3x3 window. Reads the stores at accept, then
// builds the column and shifts the window one stage later. Uses sem_pkg, sem_line_ram.
module sem_window (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  logic                 accept,
    input  sem_pkg::item_info_t  info,
    input  sem_pkg::pixel_t      pixel,
    output sem_pkg::grad_beat_t  beat
);
    import sem_pkg::*;

    logic       s1_valid_reg;
    item_info_t s1_info_reg;
    pixel_t     s1_pixel_reg;
    logic       fwd_hit_reg;
    pixel_t     fwd_upper_reg;
    pixel_t     fwd_middle_reg;
    window_t    win_reg, win_next;
    logic       s2_valid_reg;
    window_t    s2_win_reg;
    logic       s2_row_end_reg;
    logic       s2_image_end_reg;

    pixel_t  upper_rd, middle_rd;
    pixel_t  top, mid, bot;
    window_t mag_win;
    logic    s1_write;

    assign s1_write = s1_valid_reg && adv;

    sem_line_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_upper_ram (
        .aclk  (aclk),
        .we    (s1_write),
        .waddr (s1_info_reg.col),
        .wdata (mid),
        .re    (accept),
        .raddr (info.col),
        .rdata (upper_rd)
    );

    sem_line_ram #(.WIDTH(PIXEL_BITS), .DEPTH(MAX_WIDTH)) u_middle_ram (
        .aclk  (aclk),
        .we    (s1_write),
        .waddr (s1_info_reg.col),
        .wdata (bot),
        .re    (accept),
        .raddr (info.col),
        .rdata (middle_rd)
    );

    always_comb begin
        // A write to the same column on the read edge is not seen by the RAM read.
        mid = fwd_hit_reg ? fwd_middle_reg : middle_rd;
        if (s1_info_reg.top_from_mid) begin
            top = mid;
        end else begin
            top = fwd_hit_reg ? fwd_upper_reg : upper_rd;
        end
        bot = s1_info_reg.take_pixel ? s1_pixel_reg : mid;

        // At column zero the right border repeats the last column.
        mag_win[2:0] = win_reg[5:3];
        mag_win[5:3] = win_reg[8:6];
        mag_win[8:6] = s1_info_reg.first_col ? win_reg[8:6] : {bot, mid, top};

        win_next = mag_win;
        if (s1_info_reg.first_col && !s1_info_reg.image_end) begin
            win_next[5:3] = {bot, mid, top};
            win_next[8:6] = {bot, mid, top};
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
            s2_valid_reg <= 1'b0;
            win_reg      <= '0;
        end else if (adv) begin
            s1_valid_reg <= accept;
            s2_valid_reg <= s1_valid_reg && s1_info_reg.started;
            if (s1_valid_reg) begin
                win_reg <= win_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (accept) begin
            s1_info_reg    <= info;
            s1_pixel_reg   <= pixel;
            fwd_hit_reg    <= s1_valid_reg && (s1_info_reg.col == info.col);
            fwd_upper_reg  <= mid;
            fwd_middle_reg <= bot;
        end
        if (adv) begin
            s2_win_reg       <= mag_win;
            s2_row_end_reg   <= s1_info_reg.row_end;
            s2_image_end_reg <= s1_info_reg.image_end;
        end
    end

    assign beat.valid     = s2_valid_reg;
    assign beat.win       = s2_win_reg;
    assign beat.row_end   = s2_row_end_reg;
    assign beat.image_end = s2_image_end_reg;

    // A bubble in the first stage never turns into a result.
    a_bubble_stays_bubble: assert property (@(posedge aclk) disable iff (!aresetn)
        adv && !s1_valid_reg |=> !s2_valid_reg)
        else $error("result created from an empty stage");

endmodule

[rtl/sem_grad.sv]
`timescale 1ns / 1ps
// Scharr gradient magnitude on the registered window and the result
// register that drives the output channel. Uses sem_pkg.
module sem_grad (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 adv,
    input  sem_pkg::grad_beat_t  beat,
    output logic                 m_valid,
    output sem_pkg::pixel_t      m_edge_value,
    output logic                 m_row_end,
    output logic                 m_image_end
);
    import sem_pkg::*;

    logic   out_valid_reg;
    pixel_t out_edge_reg;
    logic   out_row_end_reg;
    logic   out_image_end_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= beat.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            out_edge_reg      <= scharr_mag(beat.win);
            out_row_end_reg   <= beat.row_end;
            out_image_end_reg <= beat.image_end;
        end
    end

    assign m_valid      = out_valid_reg;
    assign m_edge_value = out_edge_reg;
    assign m_row_end    = out_row_end_reg;
    assign m_image_end  = out_image_end_reg;

endmodule

[rtl/scharr_edge_magnitude_3x3.sv]
`timescale 1ns / 1ps
// Top level of the streaming 3x3 Scharr edge-magnitude block.
// Uses sem_pkg, sem_ctrl, sem_window, sem_grad.
//
//   channel  | handshake          | payload
//   ---------+--------------------+-------------------------------------------
//   input    | s_valid / s_ready  | s_mode, s_pixel
//   result   | m_valid / m_ready  | m_edge_value, m_row_end, m_image_end
//   config   | cfg_wr_en          | cfg_index, cfg_data
//
// One beat is taken per cycle while the result side keeps up; the single
// read and write port of each line store per cycle sets that figure.
// A taken beat passes through the first-stage registers, the window stage and the result register.
// A result held by m_ready low stalls the whole pipeline and drops s_ready.
// Reset clears the counters and window and loads width 640 and height 480;
// the line stores are not cleared and need no clearing pass.
module scharr_edge_magnitude_3x3 (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic                               s_mode,
    input  logic [sem_pkg::PIXEL_BITS-1:0]     s_pixel,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic [sem_pkg::PIXEL_BITS-1:0]     m_edge_value,
    output logic                               m_row_end,
    output logic                               m_image_end,
    input  logic                               cfg_wr_en,
    input  logic [sem_pkg::CFG_INDEX_BITS-1:0] cfg_index,
    input  logic [sem_pkg::CFG_DATA_BITS-1:0]  cfg_data
);
    import sem_pkg::*;

    logic       adv;
    logic       accept;
    item_info_t info;
    grad_beat_t beat;

    assign adv     = !m_valid || m_ready;
    assign s_ready = adv;
    assign accept  = s_valid && adv;

    sem_ctrl u_ctrl (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .accept    (accept),
        .mode      (item_mode_t'(s_mode)),
        .info      (info)
    );

    sem_window u_window (
        .aclk    (aclk),
        .aresetn (aresetn),
        .adv     (adv),
        .accept  (accept),
        .info    (info),
        .pixel   (s_pixel),
        .beat    (beat)
    );

    sem_grad u_grad (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .adv          (adv),
        .beat         (beat),
        .m_valid      (m_valid),
        .m_edge_value (m_edge_value),
        .m_row_end    (m_row_end),
        .m_image_end  (m_image_end)
    );

    // The last pixel of an image is always the last pixel of its row.
    a_image_end_is_row_end: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_image_end |-> m_row_end)
        else $error("image end flagged without row end");

endmodule

[tb/scharr_edge_magnitude_3x3_tb.sv]
`timescale 1ns / 1ps
// Testbench for the streaming 3x3 Scharr edge-magnitude block: random and directed images,
// with an edge-map predictor in a scoreboard class that checks every result beat.
// Depends on sem_pkg and scharr_edge_magnitude_3x3.
module scharr_edge_magnitude_3x3_tb;
    import sem_pkg::*;

    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 8;
    localparam int STALL_LIMIT   = 5000;
    localparam int RANDOM_BEATS  = 1400;
    localparam int FILL_WIDTH    = 128;

    typedef enum int {
        FILL_NOISE,
        FILL_EXTREME,
        FILL_RAMP
    } fill_t;

    typedef struct {
        pixel_t edge_value;
        logic   row_end;
        logic   image_end;
    } edge_result_t;

    class edge_scoreboard;
        logic [WIDTH_BITS-1:0]  width_reg;
        logic [HEIGHT_BITS-1:0] height_reg;
        pixel_t                 upper_line[MAX_WIDTH];
        pixel_t                 middle_line[MAX_WIDTH];
        bit                     upper_written[MAX_WIDTH];
        bit                     middle_written[MAX_WIDTH];
        pixel_t                 win[9];
        int unsigned            in_col;
        int unsigned            in_row;
        int unsigned            out_col;
        int unsigned            out_row;
        edge_result_t           expected_edges[$];
        int                     errors;

        function new();
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            foreach (win[i]) win[i] = '0;
            foreach (middle_written[i]) begin
                middle_written[i] = 1'b0;
                upper_written[i]  = 1'b0;
            end
            in_col  = 0;
            in_row  = 0;
            out_col = 0;
            out_row = 0;
            errors  = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
            if (idx == REG_IMAGE_WIDTH) begin
                width_reg = data[WIDTH_BITS-1:0];
            end else begin
                height_reg = data[HEIGHT_BITS-1:0];
            end
        endfunction

        function int unsigned eff_width();
            if (width_reg == 0) return 1;
            if (width_reg > MAX_WIDTH) return MAX_WIDTH;
            return width_reg;
        endfunction

        function int unsigned eff_height();
            return (height_reg == 0) ? 1 : height_reg;
        endfunction

        function int unsigned next_col();
            return (in_col >= eff_width()) ? 0 : in_col;
        endfunction

        // A flush beat consumes the line-store entries of its column, so those must hold data.
        function bit flush_safe();
            int unsigned x;
            x = next_col();
            return middle_written[x] && (in_row < 2 || upper_written[x]);
        endfunction

        function bit at_image_start();
            return in_col == 0 && in_row == 0 && out_col == 0 && out_row == 0;
        endfunction

        function int pending();
            return expected_edges.size();
        endfunction

        function int tap(pixel_t a, pixel_t b, pixel_t c);
            return 3 * (int'(a) + int'(c)) + 10 * int'(b);
        endfunction

        function pixel_t window_magnitude();
            int gx;
            int gy;
            int sum;
            gx = tap(win[0], win[1], win[2]) - tap(win[6], win[7], win[8]);
            gy = tap(win[0], win[3], win[6]) - tap(win[2], win[5], win[8]);
            if (gx < 0) gx = -gx;
            if (gy < 0) gy = -gy;
            sum = (gx + gy) >> 2;
            return (sum > 255) ? 8'd255 : pixel_t'(sum);
        endfunction

        function void take_pixel_beat(item_mode_t mode, pixel_t pix);
            int unsigned  w;
            int unsigned  h;
            int unsigned  x;
            int unsigned  y;
            pixel_t       top;
            pixel_t       mid;
            pixel_t       bot;
            edge_result_t r;
            w   = eff_width();
            h   = eff_height();
            x   = next_col();
            y   = in_row;
            mid = middle_line[x];
            top = (y <= 1) ? mid : upper_line[x];
            // Rows at or below the image height repeat the row above.
            bot = (mode == MODE_PIXEL && y < h) ? pix : mid;
            upper_line[x]     = mid;
            upper_written[x]  = 1'b1;
            middle_line[x]    = bot;
            middle_written[x] = 1'b1;

            for (int i = 0; i < 6; i++) win[i] = win[i + 3];
            if (x != 0) begin
                win[6] = top;
                win[7] = mid;
                win[8] = bot;
            end

            if (y >= 2 || (y == 1 && x >= 1)) begin
                r.edge_value = window_magnitude();
                r.row_end    = 1'b0;
                r.image_end  = 1'b0;
                out_col++;
                if (out_col >= w) begin
                    r.row_end = 1'b1;
                    out_col   = 0;
                    if (out_row + 1 >= h) r.image_end = 1'b1;
                    else out_row++;
                end
                expected_edges.push_back(r);
                if (r.image_end) begin
                    in_col  = 0;
                    in_row  = 0;
                    out_col = 0;
                    out_row = 0;
                    return;
                end
            end

            // A new row starts with its left border copied from column 0.
            if (x == 0) begin
                win[3] = top;
                win[6] = top;
                win[4] = mid;
                win[7] = mid;
                win[5] = bot;
                win[8] = bot;
            end

            if (x + 1 >= w) begin
                in_col = 0;
                in_row++;
            end else begin
                in_col = x + 1;
            end
        endfunction

        function void match_result(pixel_t edge_value, logic row_end, logic image_end);
            edge_result_t r;
            if (expected_edges.size() == 0) begin
                $display("%0t: unexpected result beat, expected none, actual edge_value %0d",
                         $time, edge_value);
                errors++;
                return;
            end
            r = expected_edges.pop_front();
            if (edge_value !== r.edge_value) begin
                $display("%0t: edge_value expected %0d actual %0d", $time, r.edge_value,
                         edge_value);
                errors++;
            end
            if (row_end !== r.row_end) begin
                $display("%0t: row_end expected %0d actual %0d", $time, r.row_end, row_end);
                errors++;
            end
            if (image_end !== r.image_end) begin
                $display("%0t: image_end expected %0d actual %0d", $time, r.image_end,
                         image_end);
                errors++;
            end
        endfunction
    endclass

    logic                      aclk;
    logic                      aresetn;
    logic                      s_valid;
    logic                      s_ready;
    logic                      s_mode;
    logic [PIXEL_BITS-1:0]     s_pixel;
    logic                      m_valid;
    logic                      m_ready;
    logic [PIXEL_BITS-1:0]     m_edge_value;
    logic                      m_row_end;
    logic                      m_image_end;
    logic                      cfg_wr_en;
    logic [CFG_INDEX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0]  cfg_data;

    edge_scoreboard edges = new();
    int             beats_sent = 0;
    int             idle_cycles = 0;
    bit             send_burst = 1'b0;
    bit             sink_burst = 1'b0;
    bit             hold_request = 1'b0;

    scharr_edge_magnitude_3x3 dut (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .s_valid     (s_valid),
        .s_ready     (s_ready),
        .s_mode      (s_mode),
        .s_pixel     (s_pixel),
        .m_valid     (m_valid),
        .m_ready     (m_ready),
        .m_edge_value(m_edge_value),
        .m_row_end   (m_row_end),
        .m_image_end (m_image_end),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_index   (cfg_index),
        .cfg_data    (cfg_data)
    );

    initial aclk = 1'b0;
    always #2 aclk = ~aclk;

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) edges.match_result(m_edge_value, m_row_end, m_image_end);
            if ((s_valid && s_ready) || (m_valid && m_ready)) begin
                idle_cycles <= 0;
            end else if (idle_cycles >= STALL_LIMIT) begin
                $display("Some tests failed");
                $finish;
            end else begin
                idle_cycles <= idle_cycles + 1;
            end
        end
    end

    // Result side: a random hold-off before each beat, with the occasional long one.
    initial begin : result_sink
        int gap;
        m_ready = 1'b0;
        wait (aresetn);
        @(negedge aclk);
        forever begin
            if ($urandom_range(0, 49) == 0) sink_burst = !sink_burst;
            gap = sink_burst ? 0 : $urandom_range(0, 11);
            if (hold_request) begin
                gap          = HOLD_CYCLES;
                hold_request = 1'b0;
            end
            if (gap > 0) begin
                m_ready <= 1'b0;
                repeat (gap) @(negedge aclk);
            end
            m_ready <= 1'b1;
            do @(posedge aclk); while (!m_valid);
            @(negedge aclk);
        end
    end

    function automatic pixel_t pick_pixel(fill_t fill, int k, int w);
        case (fill)
            FILL_NOISE:   return pixel_t'($urandom);
            FILL_EXTREME: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
            default:      return pixel_t'(k * 7 + (k / w) * 29);
        endcase
    endfunction

    task automatic send_item(item_mode_t mode, pixel_t pix);
        int gap;
        if (mode == MODE_FLUSH && !edges.flush_safe()) mode = MODE_PIXEL;
        if ($urandom_range(0, 49) == 0) send_burst = !send_burst;
        gap = send_burst ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_mode  <= mode;
        s_pixel <= pix;
        do @(posedge aclk); while (!s_ready);
        edges.take_pixel_beat(mode, pix);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_pixels(fill_t fill, int count, int w);
        for (int k = 0; k < count; k++) send_item(MODE_PIXEL, pick_pixel(fill, k, w));
    endtask

    // Beats that end in the bottom border cause no result, so allow the pipeline to settle.
    task automatic wait_idle();
        s_valid <= 1'b0;
        while (edges.pending() != 0) @(negedge aclk);
        repeat (SETTLE_CYCLES) @(negedge aclk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [CFG_DATA_BITS-1:0] data);
        wait_idle();
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(negedge aclk);
        cfg_wr_en <= 1'b0;
        edges.set_reg(idx, data);
    endtask

    task automatic finish_image();
        while (!edges.at_image_start()) begin
            send_item($urandom_range(0, 1) ? MODE_FLUSH : MODE_PIXEL, pixel_t'($urandom));
        end
    endtask

    initial begin : stimulus
        int    w;
        int    h;
        int    rows;
        int    count;
        int    start_beats;
        fill_t fill;
        aresetn   = 1'b0;
        s_valid   = 1'b0;
        s_mode    = MODE_PIXEL;
        s_pixel   = '0;
        cfg_wr_en = 1'b0;
        cfg_index = REG_IMAGE_WIDTH;
        cfg_data  = '0;
        repeat (12) @(negedge aclk);
        aresetn <= 1'b1;
        @(negedge aclk);

        // A wide first row at height zero fills the line-store entries that later images read.
        write_reg(REG_IMAGE_WIDTH, 16'(FILL_WIDTH));
        write_reg(REG_IMAGE_HEIGHT, 16'd0);
        send_pixels(FILL_EXTREME, FILL_WIDTH, FILL_WIDTH);
        finish_image();

        // Single-column images, with width one and width zero.
        write_reg(REG_IMAGE_WIDTH, 16'd1);
        write_reg(REG_IMAGE_HEIGHT, 16'd3);
        send_item(MODE_PIXEL, 8'h00);
        send_item(MODE_PIXEL, 8'hFF);
        send_item(MODE_PIXEL, 8'h00);
        finish_image();
        write_reg(REG_IMAGE_WIDTH, 16'h0000);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        send_item(MODE_PIXEL, 8'hFF);
        send_item(MODE_PIXEL, 8'h00);
        finish_image();

        // A tall image with an early flush, cut short by lowering the height.
        write_reg(REG_IMAGE_WIDTH, 16'd3);
        write_reg(REG_IMAGE_HEIGHT, 16'hFFFF);
        send_pixels(FILL_RAMP, 10, 3);
        send_item(MODE_FLUSH, 8'hFF);
        send_pixels(FILL_NOISE, 4, 3);
        write_reg(REG_IMAGE_HEIGHT, 16'd2);
        finish_image();

        // Width narrowed and then widened in the middle of an image.
        write_reg(REG_IMAGE_WIDTH, 16'd5);
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        send_pixels(FILL_NOISE, 7, 5);
        write_reg(REG_IMAGE_WIDTH, 16'd2);
        send_pixels(FILL_EXTREME, 5, 2);
        write_reg(REG_IMAGE_WIDTH, 16'd7);
        send_pixels(FILL_RAMP, 9, 7);
        finish_image();

        // Checkerboard drives the magnitude into saturation.
        write_reg(REG_IMAGE_WIDTH, 16'd4);
        write_reg(REG_IMAGE_HEIGHT, 16'd4);
        for (int k = 0; k < 16; k++) send_item(MODE_PIXEL, ((k + k / 4) % 2) ? 8'hFF : 8'h00);
        finish_image();

        // The result side holds off for a long stretch while a full image keeps coming,
        // so the pipeline fills and the input stalls.
        write_reg(REG_IMAGE_WIDTH, 16'd16);
        write_reg(REG_IMAGE_HEIGHT, 16'd6);
        hold_request = 1'b1;
        send_pixels(FILL_NOISE, 96, 16);
        finish_image();

        start_beats = beats_sent;
        while (beats_sent - start_beats < RANDOM_BEATS) begin
            w    = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 120) : $urandom_range(1, 16);
            h    = $urandom_range(0, 6);
            rows = (h == 0) ? 1 : h;
            fill = fill_t'($urandom_range(0, 2));
            write_reg(REG_IMAGE_WIDTH, 16'(w) | (16'($urandom_range(0, 15)) << WIDTH_BITS));
            write_reg(REG_IMAGE_HEIGHT, 16'(h));
            // Now and then an image is cut short and finished with random flush and pixel beats.
            count = ($urandom_range(0, 7) == 0) ? $urandom_range(0, w * rows) : w * rows;
            for (int k = 0; k < count; k++) begin
                if ($urandom_range(0, 79) == 0) begin
                    if ($urandom_range(0, 1)) begin
                        write_reg(REG_IMAGE_WIDTH, 16'($urandom_range(1, 16)));
                    end else begin
                        write_reg(REG_IMAGE_HEIGHT, 16'($urandom_range(1, 6)));
                    end
                end
                send_item(($urandom_range(0, 19) == 0) ? MODE_FLUSH : MODE_PIXEL,
                          pick_pixel(fill, k, w));
            end
            finish_image();
        end

        wait_idle();
        repeat (20) @(negedge aclk);
        if (edges.errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

[sim.f]
rtl/sem_pkg.sv
rtl/sem_line_ram.sv
rtl/sem_ctrl.sv
rtl/sem_window.sv
rtl/sem_grad.sv
rtl/scharr_edge_magnitude_3x3.sv
tb/scharr_edge_magnitude_3x3_tb.sv
